### rtl/core/fsha_pkg.sv
`default_nettype none
package fsha_pkg;
    localparam int unsigned HEAP_UNITS    = 64;
    localparam int unsigned TABLE_ENTRIES = 32;
    localparam int unsigned NAME_BITS     = 8;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_COPY  = 2'd2;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_WORST = 2'd1;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NO_HOLE = 3'd1;
    localparam logic [2:0] ST_NO_NAME = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_BAD_SZ  = 3'd4;

    localparam int unsigned STATE_BITS = 3;
    localparam logic [STATE_BITS-1:0] S_IDLE  = 3'd0;
    localparam logic [STATE_BITS-1:0] S_FIND  = 3'd1;
    localparam logic [STATE_BITS-1:0] S_SCAN  = 3'd2;
    localparam logic [STATE_BITS-1:0] S_MARK  = 3'd3;
    localparam logic [STATE_BITS-1:0] S_FREE  = 3'd4;
    localparam logic [STATE_BITS-1:0] S_CLEAR = 3'd5;
    localparam logic [STATE_BITS-1:0] S_DONE  = 3'd6;
endpackage
`default_nettype wire

### rtl/core/fit_strategy_heap_allocator_unit.sv
// allocate: the heap scan (S_SCAN) finds a hole, S_MARK sets its units, S_DONE posts the result.
// copy first searches the table for the source (S_FIND); bad size or full table go straight to S_DONE.
// free walks the table (S_FREE) and clears the units of every released block (S_CLEAR).
// one request at a time, the heap scan walks one unit per cycle through a single comparator.
// o_ready stays low during the work and while a word waits.
// reset (synchronous, active low) frees the whole heap, empties the table, sets first fit.
`default_nettype none
module fit_strategy_heap_allocator_unit
    import fsha_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire  [1:0] i_fit_mode,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire  [1:0] i_req_type,
    input  wire  [7:0] i_var_id,
    input  wire  [6:0] i_alloc_size,
    input  wire  [7:0] i_source_id,
    output logic       o_valid,
    input  wire        i_ready,
    output logic [2:0] o_status,
    output logic [5:0] o_block_start,
    output logic [6:0] o_block_size,
    output logic [5:0] o_freed_count
);
    localparam int unsigned UB = $clog2(HEAP_UNITS);
    localparam int unsigned UC = $clog2(HEAP_UNITS + 1);
    localparam int unsigned EB = $clog2(TABLE_ENTRIES);
    localparam int unsigned EC = $clog2(TABLE_ENTRIES + 1);

    typedef struct packed {
        logic [NAME_BITS-1:0] name;
        logic [NAME_BITS-1:0] ref_name;
        logic                 has_ref;
        logic [UB-1:0]        start;
        logic [UC-1:0]        size;
    } t_entry;

    t_entry                  r_tab [TABLE_ENTRIES];
    logic [HEAP_UNITS-1:0]   r_occ;
    logic [EC-1:0]           r_count;
    logic [1:0]              r_fit;
    logic [STATE_BITS-1:0]   r_state;
    logic [1:0]              r_req;
    logic [NAME_BITS-1:0]    r_name, r_src;
    logic [UC-1:0]           r_size;
    logic [UC:0]             r_u;
    logic [UB-1:0]           r_run_start, r_best_start, r_mark;
    logic [UC-1:0]           r_run_len, r_best_len, r_left;
    logic                    r_found;
    logic [EC-1:0]           r_i, r_keep;
    logic [EC-1:0]           r_freed;
    logic [2:0]              r_status;
    logic [5:0]              r_o_start;
    logic [6:0]              r_o_size;
    logic                    r_out_v;

    t_entry cur;
    logic   hit, take, free_u;
    assign cur = r_tab[r_i[EB-1:0]];
    assign hit = (cur.name == r_name) || (cur.has_ref && cur.ref_name == r_name);
    assign free_u = (r_u < (UC+1)'(HEAP_UNITS)) && !r_occ[r_u[UB-1:0]];

    always_comb begin
        if (!r_found) begin
            take = 1'b1;
        end else if (r_fit == FIT_FIRST) begin
            take = 1'b0;
        end else if (r_fit == FIT_WORST) begin
            take = r_run_len > r_best_len;
        end else begin
            take = r_run_len < r_best_len;
        end
    end

    assign o_ready     = (r_state == S_IDLE) && !r_out_v;
    assign o_cfg_ready = o_ready && !i_valid;
    assign o_valid     = r_out_v;
    assign o_status      = r_status;
    assign o_block_start = r_o_start;
    assign o_block_size  = r_o_size;
    assign o_freed_count = 6'(r_freed);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_count <= '0;
            r_fit   <= FIT_FIRST;
            r_out_v <= 1'b0;
        end else begin
            if (r_out_v && i_ready) r_out_v <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) r_fit <= i_fit_mode;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_req  <= i_req_type;
                        r_name <= i_var_id[NAME_BITS-1:0];
                        r_src  <= i_source_id[NAME_BITS-1:0];
                        r_i    <= '0;
                        r_keep <= '0;
                        r_freed <= '0;
                        r_u    <= '0;
                        r_run_len <= '0;
                        r_found <= 1'b0;
                        r_best_start <= '0;
                        r_best_len <= '0;
                        if (i_req_type == REQ_FREE) begin
                            r_state <= S_FREE;
                        end else if (i_req_type == REQ_COPY) begin
                            r_state <= S_FIND;
                        end else if (i_alloc_size == 7'd0 ||
                                     32'(i_alloc_size) > HEAP_UNITS) begin
                            r_status <= ST_BAD_SZ;
                            r_state  <= S_DONE;
                        end else if (r_count >= EC'(TABLE_ENTRIES)) begin
                            r_status <= ST_FULL;
                            r_state  <= S_DONE;
                        end else begin
                            r_size  <= UC'(i_alloc_size);
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_FIND: begin
                    if (r_i >= r_count) begin
                        r_status <= ST_NO_NAME;
                        r_state  <= S_DONE;
                    end else if (cur.name == r_src) begin
                        r_size <= cur.size;
                        if (r_count >= EC'(TABLE_ENTRIES)) begin
                            r_status <= ST_FULL;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_SCAN: begin
                    // one unit per cycle, one extra step closes the last run
                    if (free_u) begin
                        if (r_run_len == '0) r_run_start <= r_u[UB-1:0];
                        r_run_len <= r_run_len + 1'b1;
                        r_u <= r_u + 1'b1;
                    end else begin
                        if (r_run_len >= r_size && r_run_len != '0 && take) begin
                            r_found <= 1'b1;
                            r_best_start <= r_run_start;
                            r_best_len <= r_run_len;
                        end
                        r_run_len <= '0;
                        if (r_u == (UC+1)'(HEAP_UNITS)) begin
                            r_state <= S_MARK;
                            r_mark  <= (r_run_len >= r_size && r_run_len != '0 && take)
                                       ? r_run_start : r_best_start;
                            r_left  <= r_size;
                        end else begin
                            r_u <= r_u + 1'b1;
                        end
                    end
                end
                S_MARK: begin
                    if (!r_found) begin
                        r_status <= ST_NO_HOLE;
                        r_state  <= S_DONE;
                    end else if (r_left != '0) begin
                        r_occ[r_mark] <= 1'b1;
                        r_mark <= r_mark + 1'b1;
                        r_left <= r_left - 1'b1;
                    end else begin
                        r_tab[r_count[EB-1:0]] <= '{name: r_name,
                            ref_name: (r_req == REQ_COPY) ? r_src : '0,
                            has_ref: (r_req == REQ_COPY), start: r_best_start,
                            size: r_size};
                        r_count  <= r_count + 1'b1;
                        r_status <= ST_OK;
                        r_state  <= S_DONE;
                    end
                end
                S_FREE: begin
                    if (r_i >= r_count) begin
                        r_count  <= r_keep;
                        r_status <= (r_freed != '0) ? ST_OK : ST_NO_NAME;
                        r_state  <= S_DONE;
                    end else if (hit) begin
                        r_mark  <= cur.start;
                        r_left  <= cur.size;
                        r_freed <= r_freed + 1'b1;
                        r_state <= S_CLEAR;
                    end else begin
                        r_tab[r_keep[EB-1:0]] <= cur;
                        r_keep <= r_keep + 1'b1;
                        r_i <= r_i + 1'b1;
                    end
                end
                S_CLEAR: begin
                    if (r_left != '0) begin
                        r_occ[r_mark] <= 1'b0;
                        r_mark <= r_mark + 1'b1;
                        r_left <= r_left - 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_FREE;
                    end
                end
                S_DONE: begin
                    r_out_v   <= 1'b1;
                    r_o_start <= (r_status == ST_OK && r_req != REQ_FREE)
                                 ? 6'(r_best_start) : 6'd0;
                    r_o_size  <= (r_status == ST_OK && r_req != REQ_FREE)
                                 ? 7'(r_size) : 7'd0;
                    if (r_req != REQ_FREE) r_freed <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### bench/fit_strategy_heap_allocator_unit_tb.sv
`default_nettype none
module fit_strategy_heap_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fsha_pkg::*;

    localparam int HEAP = 64;
    localparam int SLOTS = 32;
    localparam logic [1:0] FIT_ODD = 2'd3;
    localparam logic [1:0] REQ_ODD = 2'd3;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] start;
        logic [6:0] size;
        logic [5:0] freed;
    } t_alloc_word;

    // allocator shadow: heap map, block table and the resulting words
    class heap_scoreboard;
        bit used[HEAP];
        logic [7:0] nm[SLOTS];
        logic [7:0] rf[SLOTS];
        bit has_rf[SLOTS];
        int bstart[SLOTS];
        int bsize[SLOTS];
        int count;
        logic [1:0] mode;
        t_alloc_word pending[$];
        int errors;

        function void clear();
            foreach (used[u]) used[u] = 0;
            count = 0;
            mode = FIT_FIRST;
            pending.delete();
        endfunction

        function int pick(int need);
            int found, best_s, best_l, rs, rl;
            bit take;
            found = 0; best_s = 0; best_l = 0; rs = 0; rl = 0;
            for (int u = 0; u <= HEAP; u++) begin
                if (u < HEAP && !used[u]) begin
                    if (rl == 0) rs = u;
                    rl++;
                end else begin
                    if (rl >= need && rl > 0) begin
                        if (!found) take = 1;
                        else if (mode == FIT_FIRST) take = 0;
                        else if (mode == FIT_WORST) take = rl > best_l;
                        else take = rl < best_l;
                        if (take) begin
                            found = 1; best_s = rs; best_l = rl;
                        end
                    end
                    rl = 0;
                end
            end
            return found ? best_s : -1;
        endfunction

        function logic [2:0] place(logic [7:0] name, int sz, bit r, logic [7:0] src,
                                   output int at);
            at = 0;
            if (count >= SLOTS) return ST_FULL;
            at = pick(sz);
            if (at < 0) begin
                at = 0;
                return ST_NO_HOLE;
            end
            for (int u = at; u < at + sz && u < HEAP; u++) used[u] = 1;
            nm[count] = name; rf[count] = r ? src : 8'd0; has_rf[count] = r;
            bstart[count] = at; bsize[count] = sz;
            count++;
            return ST_OK;
        endfunction

        function void note_request(logic [1:0] req, logic [7:0] id, logic [6:0] sz,
                                   logic [7:0] src);
            t_alloc_word w;
            int at, keep, k;
            w = '0;
            at = 0;
            if (req == REQ_FREE) begin
                keep = 0;
                for (int i = 0; i < count; i++) begin
                    if (nm[i] == id || (has_rf[i] && rf[i] == id)) begin
                        for (int u = bstart[i]; u < bstart[i] + bsize[i] && u < HEAP; u++)
                            used[u] = 0;
                        w.freed++;
                    end else begin
                        nm[keep] = nm[i]; rf[keep] = rf[i]; has_rf[keep] = has_rf[i];
                        bstart[keep] = bstart[i]; bsize[keep] = bsize[i];
                        keep++;
                    end
                end
                count = keep;
                w.status = (w.freed != 0) ? ST_OK : ST_NO_NAME;
            end else if (req == REQ_COPY) begin
                k = -1;
                for (int i = 0; i < count; i++)
                    if (k < 0 && nm[i] == src) k = i;
                if (k < 0) w.status = ST_NO_NAME;
                else begin
                    w.status = place(id, bsize[k], 1, src, at);
                    w.size = 7'(bsize[k]);
                end
            end else begin
                if (sz == 0 || sz > HEAP) w.status = ST_BAD_SZ;
                else begin
                    w.status = place(id, sz, 0, 8'd0, at);
                    w.size = sz;
                end
            end
            if (w.status != ST_OK) begin
                at = 0;
                w.size = 0;
            end
            w.start = 6'(at);
            pending.push_back(w);
        endfunction

        function void check_result(t_alloc_word got);
            t_alloc_word exp_w;
            if (pending.size() == 0) begin
                report("result with nothing pending", 0, 0);
                return;
            end
            exp_w = pending.pop_front();
            if (got.status != exp_w.status) report("status", got.status, exp_w.status);
            if (got.start != exp_w.start) report("block_start", got.start, exp_w.start);
            if (got.size != exp_w.size) report("block_size", got.size, exp_w.size);
            if (got.freed != exp_w.freed) report("freed_count", got.freed, exp_w.freed);
        endfunction

        function void report(string what, int got, int want);
            $display("mismatch %s: got %0d want %0d", what, got, want);
            errors++;
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_valid = 0;
    logic [1:0] i_fit_mode = '0;
    logic i_valid = 0;
    logic [1:0] i_req_type = '0;
    logic [7:0] i_var_id = '0;
    logic [6:0] i_alloc_size = '0;
    logic [7:0] i_source_id = '0;
    logic i_ready = 0;
    wire o_cfg_ready, o_ready, o_valid;
    wire [2:0] o_status;
    wire [5:0] o_block_start;
    wire [6:0] o_block_size;
    wire [5:0] o_freed_count;

    fit_strategy_heap_allocator_unit dut (.*);

    heap_scoreboard board = new();
    int send_idle = 0;
    int recv_stall = 0;
    bit hold_off = 0;
    int quiet = 0;
    logic [7:0] names[$];

    initial forever #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_result({o_status, o_block_start, o_block_size, o_freed_count});
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("fit_strategy_heap_allocator_unit verification failed");
            $finish;
        end
    end

    // receiver: random stalls unless held off
    always @(posedge i_clk) begin
        if (hold_off) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic send_word(logic [1:0] req, logic [7:0] id, logic [6:0] sz, logic [7:0] src);
        while ($urandom_range(99) < send_idle) @(posedge i_clk);
        i_valid <= 1'b1;
        i_req_type <= req; i_var_id <= id; i_alloc_size <= sz; i_source_id <= src;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_request(req, id, sz, src);
        i_valid <= 1'b0;
        // the block stays busy after an accept, so this gap costs nothing
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic set_mode(logic [1:0] m);
        drain();
        i_cfg_valid <= 1'b1;
        i_fit_mode <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        board.mode = m;
    endtask

    // mostly known names so copies and frees hit, small sizes so the table churns
    task automatic random_word();
        int r;
        logic [7:0] id, src;
        logic [6:0] sz;
        r = $urandom_range(99);
        id = (names.size() > 0 && $urandom_range(3) == 0) ?
             names[$urandom_range(names.size() - 1)] : 8'($urandom);
        src = (names.size() > 0 && $urandom_range(4) != 0) ?
              names[$urandom_range(names.size() - 1)] : 8'($urandom);
        sz = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 8));
        if (r < 50) begin
            send_word((r < 3) ? REQ_ODD : REQ_ALLOC, id, sz, 8'($urandom));
            names.push_back(id);
            if (names.size() > 40) void'(names.pop_front());
        end else if (r < 78) begin
            send_word(REQ_FREE, names.size() > 0 && r < 74 ?
                      names[$urandom_range(names.size() - 1)] : 8'($urandom), 7'($urandom),
                      8'($urandom));
        end else begin
            send_word(REQ_COPY, id, 7'($urandom), src);
            names.push_back(id);
        end
    endtask

    initial begin
        board.clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: size extremes, every request type, full table, unknown names
        send_word(REQ_ALLOC, 8'h00, 7'd0, 8'h00);
        send_word(REQ_ALLOC, 8'hff, 7'd65, 8'hff);
        send_word(REQ_ALLOC, 8'hff, 7'd127, 8'h00);
        send_word(REQ_ALLOC, 8'hff, 7'd64, 8'h00);
        send_word(REQ_ALLOC, 8'h01, 7'd1, 8'h00);
        send_word(REQ_COPY, 8'h02, 7'd0, 8'hff);
        send_word(REQ_FREE, 8'hff, 7'd0, 8'h00);
        send_word(REQ_FREE, 8'h55, 7'h7f, 8'hff);
        for (int i = 0; i < 33; i++)
            send_word(i[0] ? REQ_ODD : REQ_ALLOC, 8'(8'h10 + (i % 3)), 7'd1, 8'(i));
        send_word(REQ_COPY, 8'h20, 7'd0, 8'h10);
        send_word(REQ_FREE, 8'h10, 7'd0, 8'h00);
        send_word(REQ_COPY, 8'haa, 7'd5, 8'h11);
        send_word(REQ_FREE, 8'h11, 7'd0, 8'h00);
        send_word(REQ_FREE, 8'h12, 7'd0, 8'h00);
        send_word(REQ_FREE, 8'haa, 7'd0, 8'h00);

        for (int ph = 0; ph < 8; ph++) begin
            set_mode(ph == 7 ? FIT_ODD : 2'(ph % 3));
            case (ph % 4)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 70; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 70; end
                default: begin send_idle = 25; recv_stall = 25; end
            endcase
            if (ph == 2) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (2000) @(posedge i_clk);
                        hold_off = 0;
                    end
                    repeat (6) random_word();
                join
            end
            for (int n = 0; n < 70; n++) begin
                random_word();
                if (n == 35) drain();
            end
        end

        drain();
        if (board.errors == 0)
            $display("fit_strategy_heap_allocator_unit verification clean");
        else
            $display("fit_strategy_heap_allocator_unit verification failed");
        $finish;
    end
endmodule
`default_nettype wire
